// File: hdl/gum_pkg.sv
// shared types, constants and defaults for the gaussian unsharp mask core
`default_nettype none
package gum_pkg;

  localparam int DEF_KERNEL_SIZE = 15;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_TAP_BITS    = 16;

  localparam int DIM_W     = 11;
  localparam int IDX_W     = 2 * DIM_W;
  localparam int TAP_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 8;
  localparam int SLOT_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_LOW     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_HIGH    = 8'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic                 first_dy;
    logic                 last_dy;
    logic                 first_dx;
    logic                 last_dx;
    logic                 center;
    logic [TAP_IDX_W-1:0] tap_y;
    logic [TAP_IDX_W-1:0] tap_x;
  } win_tag_t;

endpackage
`default_nettype wire

// File: hdl/gum_line_store.sv
// pixel line store, one write port and one registered read port
`default_nettype none
module gum_line_store #(
  parameter int AW = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [0:(1 << AW) - 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/gum_filter_pipe.sv
// separable multiply-accumulate datapath: vertical sums, horizontal sum, sharpen
`default_nettype none
module gum_filter_pipe #(
  parameter int KERNEL_SIZE = gum_pkg::DEF_KERNEL_SIZE,
  parameter int TAP_BITS    = gum_pkg::DEF_TAP_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           rd_data,
  input  wire gum_pkg::win_tag_t    tag,
  input  wire logic [((KERNEL_SIZE - 1) / 2 + 1) * TAP_BITS - 1:0] taps_flat,
  output logic                      done,
  output logic [7:0]                blurred,
  output logic [7:0]                sharpened
);

  localparam int PW = 8 + TAP_BITS;
  localparam int VW = PW + 4;
  localparam int HP = 16 + TAP_BITS;
  localparam int HW = HP + 4;

  gum_pkg::win_tag_t t3;
  logic [PW-1:0]     prod;
  logic [7:0]        orig;
  logic [VW-1:0]     vacc;
  logic [VW-1:0]     vsum;
  logic [VW-1:0]     vsh;
  logic              v4_valid;
  logic              v4_first;
  logic              v4_last;
  logic [gum_pkg::TAP_IDX_W-1:0] v4_tap;
  logic [15:0]       vcol;
  logic              h5_valid;
  logic              h5_first;
  logic              h5_last;
  logic [HP-1:0]     hprod;
  logic [HW-1:0]     hacc;
  logic [HW-1:0]     hsum;
  logic [HW-1:0]     hsh;
  logic [7:0]        bval;
  logic [9:0]        sdiff;
  logic [TAP_BITS-1:0] tap_y;
  logic [TAP_BITS-1:0] tap_x;

  assign tap_y = taps_flat[tag.tap_y * TAP_BITS +: TAP_BITS];
  assign tap_x = taps_flat[v4_tap * TAP_BITS +: TAP_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      t3.valid <= 1'b0;
    end else begin
      t3.valid <= tag.valid;
    end
    t3.first_dy <= tag.first_dy;
    t3.last_dy  <= tag.last_dy;
    t3.first_dx <= tag.first_dx;
    t3.last_dx  <= tag.last_dx;
    t3.center   <= tag.center;
    t3.tap_y    <= tag.tap_y;
    t3.tap_x    <= tag.tap_x;
    prod        <= PW'(rd_data * tap_y);
    if (tag.valid && tag.center) begin
      orig <= rd_data;
    end
  end

  always_comb begin
    vsum = (t3.first_dy ? '0 : vacc) + VW'(prod);
    vsh  = vsum >> (TAP_BITS - 8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4_valid <= 1'b0;
    end else begin
      v4_valid <= t3.valid && t3.last_dy;
    end
    if (t3.valid) begin
      vacc <= vsum;
    end
    v4_first <= t3.first_dx;
    v4_last  <= t3.last_dx;
    v4_tap   <= t3.tap_x;
    vcol     <= (|vsh[VW-1:16]) ? 16'hFFFF : vsh[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h5_valid <= 1'b0;
    end else begin
      h5_valid <= v4_valid;
    end
    h5_first <= v4_first;
    h5_last  <= v4_last;
    hprod    <= HP'(vcol * tap_x);
  end

  always_comb begin
    hsum  = (h5_first ? '0 : hacc) + HW'(hprod);
    hsh   = hsum >> (TAP_BITS + 8);
    bval  = (|hsh[HW-1:8]) ? 8'hFF : hsh[7:0];
    sdiff = {1'b0, orig, 1'b0} - {2'b00, bval};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h5_valid && h5_last;
    end
    if (h5_valid) begin
      hacc <= hsum;
    end
    if (h5_valid && h5_last) begin
      blurred <= bval;
      if (sdiff[9]) begin
        sharpened <= 8'd0;
      end else if (sdiff[8]) begin
        sharpened <= 8'hFF;
      end else begin
        sharpened <= sdiff[7:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/gaussian_unsharp_mask_core.sv
// top level: frame control, window sequencer, address generation, output word
//
//   channel   dir  handshake            payload
//   in        in   in_valid / in_stall   mode, pixel
//   out       out  out_valid / out_stall blurred, sharpened, last
//   cfg       in   cfg_we                cfg_index, cfg_data
//
// a word that yields a result is answered after one line store read per window tap;
// the next word is taken once that result is loaded into the output word; other words
// are taken without leaving idle
// a write to one of the four config registers, and reset, hold off input while frame sizes settle
// rst is synchronous; no clearing pass, the store is only read where written
// the result sits in the output word; a stalled output holds the next result back
`default_nettype none
module gaussian_unsharp_mask_core #(
  parameter int KERNEL_SIZE = gum_pkg::DEF_KERNEL_SIZE,
  parameter int MAX_WIDTH   = gum_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = gum_pkg::DEF_MAX_HEIGHT,
  parameter int TAP_BITS    = gum_pkg::DEF_TAP_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            mode,
  input  wire logic [7:0]                      pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           blurred,
  output logic [7:0]                           sharpened,
  output logic                                 last,
  input  wire logic                            cfg_we,
  input  wire logic [gum_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gum_pkg::CFG_W-1:0]       cfg_data
);

  localparam int RADIUS = (KERNEL_SIZE - 1) / 2;
  localparam int KW     = $clog2(KERNEL_SIZE);
  localparam int AW     = $clog2(2 * (RADIUS * MAX_WIDTH + RADIUS) + 1);
  localparam int DW     = gum_pkg::DIM_W;
  localparam int XW     = gum_pkg::IDX_W;

  logic [DW-1:0] image_width;
  logic [DW-1:0] image_height;
  logic [gum_pkg::CFG_W-1:0] taps_low;
  logic [gum_pkg::CFG_W-1:0] taps_high;
  logic          settle;

  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;
  logic [XW-1:0] n_reg;
  logic [XW-1:0] d_reg;

  logic [DW-1:0] row_count;
  logic [DW-1:0] col_count;
  logic [XW-1:0] in_idx;
  logic [XW-1:0] emit_count;
  logic [DW-1:0] out_r;
  logic [DW-1:0] out_c;
  logic          cur_last;

  gum_pkg::state_t state;
  gum_pkg::state_t state_next;
  logic [KW-1:0] dx_i;
  logic [KW-1:0] dy_i;

  logic in_acc;
  logic rows_in;
  logic pix_write;
  logic start;
  logic drop_restart;
  logic last_issue;
  logic out_load;
  logic cfg_hit;

  logic [DW+1:0] pos_r;
  logic [DW+1:0] pos_c;
  logic [DW-1:0] rr;
  logic [DW-1:0] cc;
  logic [DW-1:0] rr_next;
  logic [DW-1:0] cc_next;
  logic [XW-1:0] addr_full;
  logic [AW-1:0] raddr;
  gum_pkg::win_tag_t tag0;
  gum_pkg::win_tag_t tag0_next;
  gum_pkg::win_tag_t tag1;
  gum_pkg::win_tag_t tag2;

  logic [7:0] rd_data;
  logic       done;
  logic [7:0] res_blur;
  logic [7:0] res_sharp;
  logic [(RADIUS + 1) * TAP_BITS - 1:0] taps_flat;

  // tap slots, low TAP_BITS of each
  for (genvar d = 0; d <= RADIUS; d++) begin : g_tap
    if (d < 4) begin : g_lo
      assign taps_flat[d * TAP_BITS +: TAP_BITS] =
        taps_low[d * gum_pkg::SLOT_W +: TAP_BITS];
    end else begin : g_hi
      assign taps_flat[d * TAP_BITS +: TAP_BITS] =
        taps_high[(d - 4) * gum_pkg::SLOT_W +: TAP_BITS];
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  always_ff @(posedge clk) begin
    n_reg <= XW'(w_eff * h_eff);
    d_reg <= XW'(RADIUS * w_eff + RADIUS);
  end

  always_comb begin
    case (cfg_index)
      gum_pkg::REG_IMAGE_WIDTH:  cfg_hit = cfg_we;
      gum_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
      gum_pkg::REG_TAPS_LOW:     cfg_hit = cfg_we;
      gum_pkg::REG_TAPS_HIGH:    cfg_hit = cfg_we;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gum_pkg::DIM_RESET;
      image_height <= gum_pkg::DIM_RESET;
      taps_low     <= '0;
      taps_high    <= '0;
      settle       <= 1'b1;
    end else begin
      settle <= cfg_hit;
      if (cfg_we) begin
        case (cfg_index)
          gum_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[DW-1:0];
          gum_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[DW-1:0];
          gum_pkg::REG_TAPS_LOW:     taps_low     <= cfg_data;
          gum_pkg::REG_TAPS_HIGH:    taps_high    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    in_stall     = (state != gum_pkg::ST_IDLE) || settle;
    in_acc       = in_valid && !in_stall;
    rows_in      = row_count < h_eff;
    pix_write    = in_acc && rows_in && !mode;
    start        = in_acc && ((rows_in && !mode && in_idx >= d_reg) ||
                              (!rows_in && emit_count < n_reg));
    drop_restart = in_acc && !rows_in && emit_count >= n_reg;
    last_issue   = (dx_i == KW'(KERNEL_SIZE - 1)) && (dy_i == KW'(KERNEL_SIZE - 1));
    out_load     = (state == gum_pkg::ST_HOLD) && (!out_valid || !out_stall);
    state_next   = state;
    case (state)
      gum_pkg::ST_IDLE:  if (start) state_next = gum_pkg::ST_RUN;
      gum_pkg::ST_RUN:   if (last_issue) state_next = gum_pkg::ST_DRAIN;
      gum_pkg::ST_DRAIN: if (done) state_next = gum_pkg::ST_HOLD;
      gum_pkg::ST_HOLD:  if (out_load) state_next = gum_pkg::ST_IDLE;
      default:           state_next = gum_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gum_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || cfg_hit || drop_restart || (out_load && cur_last)) begin
      row_count  <= '0;
      col_count  <= '0;
      in_idx     <= '0;
      emit_count <= '0;
      out_r      <= '0;
      out_c      <= '0;
    end else begin
      if (pix_write) begin
        in_idx <= in_idx + XW'(1);
        if (col_count + DW'(1) == w_eff) begin
          col_count <= '0;
          row_count <= row_count + DW'(1);
        end else begin
          col_count <= col_count + DW'(1);
        end
      end
      if (out_load) begin
        emit_count <= emit_count + XW'(1);
        if (out_c + DW'(1) == w_eff) begin
          out_c <= '0;
          out_r <= out_r + DW'(1);
        end else begin
          out_c <= out_c + DW'(1);
        end
      end
    end
    if (start) begin
      cur_last <= emit_count == n_reg - XW'(1);
    end
  end

  // window sequencer
  always_ff @(posedge clk) begin
    if (rst || start) begin
      dx_i <= '0;
      dy_i <= '0;
    end else if (state == gum_pkg::ST_RUN) begin
      if (dy_i == KW'(KERNEL_SIZE - 1)) begin
        dy_i <= '0;
        dx_i <= dx_i + KW'(1);
      end else begin
        dy_i <= dy_i + KW'(1);
      end
    end
  end

  // clamped row and column of the tap, its window tag and its store address
  always_comb begin
    pos_r = {2'b00, out_r} + (DW + 2)'(dy_i);
    pos_c = {2'b00, out_c} + (DW + 2)'(dx_i);
    if (pos_r < (DW + 2)'(RADIUS)) begin
      rr_next = '0;
    end else if (pos_r - (DW + 2)'(RADIUS) > {2'b00, h_eff - DW'(1)}) begin
      rr_next = h_eff - DW'(1);
    end else begin
      rr_next = DW'(pos_r - (DW + 2)'(RADIUS));
    end
    if (pos_c < (DW + 2)'(RADIUS)) begin
      cc_next = '0;
    end else if (pos_c - (DW + 2)'(RADIUS) > {2'b00, w_eff - DW'(1)}) begin
      cc_next = w_eff - DW'(1);
    end else begin
      cc_next = DW'(pos_c - (DW + 2)'(RADIUS));
    end
    tag0_next.valid    = state == gum_pkg::ST_RUN;
    tag0_next.first_dy = dy_i == '0;
    tag0_next.last_dy  = dy_i == KW'(KERNEL_SIZE - 1);
    tag0_next.first_dx = dx_i == '0;
    tag0_next.last_dx  = dx_i == KW'(KERNEL_SIZE - 1);
    tag0_next.center   = (dx_i == KW'(RADIUS)) && (dy_i == KW'(RADIUS));
    tag0_next.tap_y    = (dy_i >= KW'(RADIUS)) ? gum_pkg::TAP_IDX_W'(dy_i - KW'(RADIUS))
                                               : gum_pkg::TAP_IDX_W'(KW'(RADIUS) - dy_i);
    tag0_next.tap_x    = (dx_i >= KW'(RADIUS)) ? gum_pkg::TAP_IDX_W'(dx_i - KW'(RADIUS))
                                               : gum_pkg::TAP_IDX_W'(KW'(RADIUS) - dx_i);
    addr_full = XW'(rr * w_eff) + XW'(cc);
  end

  always_ff @(posedge clk) begin
    rr    <= rr_next;
    cc    <= cc_next;
    raddr <= addr_full[AW-1:0];
    if (rst) begin
      tag0 <= '0;
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag0 <= tag0_next;
      tag1 <= tag0;
      tag2 <= tag1;
    end
  end

  gum_line_store #(
    .AW (AW)
  ) u_store (
    .clk   (clk),
    .we    (pix_write),
    .waddr (in_idx[AW-1:0]),
    .wdata (pixel),
    .raddr (raddr),
    .rdata (rd_data)
  );

  gum_filter_pipe #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .TAP_BITS    (TAP_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .rd_data   (rd_data),
    .tag       (tag2),
    .taps_flat (taps_flat),
    .done      (done),
    .blurred   (res_blur),
    .sharpened (res_sharp)
  );

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      blurred   <= res_blur;
      sharpened <= res_sharp;
      last      <= cur_last;
    end
  end

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> state == gum_pkg::ST_DRAIN)
    else $error("window result arrived outside drain");

  a_run_exit: assert property (@(posedge clk) disable iff (rst)
    state == gum_pkg::ST_RUN |=> state == gum_pkg::ST_RUN || state == gum_pkg::ST_DRAIN)
    else $error("sequencer left run early");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    out_load && cur_last |=> emit_count == '0 && row_count == '0 && in_idx == '0)
    else $error("frame counters not cleared after last word");

endmodule
`default_nettype wire
